@@ hw/rtl/rbmm_pkg.sv @@
// ----------------------------------------------------------------------------
// rbmm_pkg
// Shared types and constants for the batched RNS modular matrix multiplier.
// ----------------------------------------------------------------------------
package rbmm_pkg;

  localparam int WORD_W    = 32;
  localparam int MOD_W     = WORD_W + 1;  // modulus zero stands for 2^32
  localparam int STEP_W    = 5;           // bit counter of the serial steps
  localparam int CFG_IDX_W = 3;
  localparam int CH_W      = 2;
  localparam int CHCNT_W   = 3;
  localparam int SIZE_W    = 4;
  localparam int BATCH_W   = 16;

  // Register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT   = 3'd6;

  typedef struct packed {
    logic [WORD_W-1:0] a_element;
    logic [WORD_W-1:0] b_element;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] product_element;
    logic              last_of_matrix;
    logic              last_of_job;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take fresh operands from the stores
    logic amod_step;  // one bit of a mod p
    logic mul_step;   // one bit of (a mod p) * b mod p
    logic acc_add;    // fold the product into the accumulator
    logic acc_first;  // first term of a dot product
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic last_of_matrix;
    logic last_of_job;
  } ctrl_stat_t;

endpackage

@@ hw/rtl/rbmm_ram.sv @@
// ----------------------------------------------------------------------------
// rbmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rbmm_dp.sv @@
// ----------------------------------------------------------------------------
// rbmm_dp
// Bit-serial modular multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module rbmm_dp import rbmm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [WORD_W-1:0] a_data_i,
  input  logic [WORD_W-1:0] b_data_i,
  input  logic [MOD_W-1:0]  modulus_i,
  output logic [WORD_W-1:0] acc_o
);

  logic [WORD_W-1:0] a_sh_q, a_sh_d, b_sh_q, b_sh_d;
  logic [WORD_W-1:0] rem_q, rem_d, prod_q, prod_d, acc_q, acc_d;
  logic [MOD_W-1:0]  rem_ext, dbl, dbl_red, sum, acc_sum, acc_base;

  always_comb begin
    a_sh_d  = a_sh_q;
    b_sh_d  = b_sh_q;
    rem_d   = rem_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    // a mod p: shift one bit of a in, subtract once
    rem_ext = {rem_q, a_sh_q[WORD_W-1]};
    // product: double, reduce, add a mod p where the bit of b is set, reduce
    dbl     = {prod_q, 1'b0};
    dbl_red = (dbl >= modulus_i) ? dbl - modulus_i : dbl;
    sum     = dbl_red + (b_sh_q[WORD_W-1] ? {1'b0, rem_q} : '0);
    acc_base = cmd_i.acc_first ? '0 : {1'b0, acc_q};
    acc_sum = acc_base + {1'b0, prod_q};
    if (cmd_i.load) begin
      a_sh_d = a_data_i;
      b_sh_d = b_data_i;
      rem_d  = '0;
      prod_d = '0;
    end
    if (cmd_i.amod_step) begin
      rem_d  = WORD_W'((rem_ext >= modulus_i) ? rem_ext - modulus_i : rem_ext);
      a_sh_d = {a_sh_q[WORD_W-2:0], 1'b0};
    end
    if (cmd_i.mul_step) begin
      prod_d = WORD_W'((sum >= modulus_i) ? sum - modulus_i : sum);
      b_sh_d = {b_sh_q[WORD_W-2:0], 1'b0};
    end
    if (cmd_i.acc_add) begin
      acc_d = WORD_W'((acc_sum >= modulus_i) ? acc_sum - modulus_i : acc_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sh_q <= a_sh_d;
    b_sh_q <= b_sh_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
  end

  assign acc_o = acc_q;

endmodule

@@ hw/rtl/rbmm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbmm_ctrl
// Sequencer: element, batch and channel counters, matrix walk and MAC steps.
// ----------------------------------------------------------------------------
module rbmm_ctrl import rbmm_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int DW      = $clog2(MAX_DIM + 1),
  parameter int ECW     = $clog2(MAX_DIM * MAX_DIM + 1),
  parameter int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [DW-1:0]      dim_i,
  input  logic [ECW-1:0]     elems_i,
  input  logic [BATCH_W-1:0] batches_i,
  input  logic [CHCNT_W-1:0] channels_i,
  output logic               busy_o,
  output logic [AW-1:0]      waddr_o,
  output logic [AW-1:0]      a_raddr_o,
  output logic [AW-1:0]      b_raddr_o,
  output logic [CH_W-1:0]    channel_o,
  output dp_cmd_t            cmd_o,
  output ctrl_stat_t         stat_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LOAD, S_AMOD, S_MUL, S_ACC, S_EMIT
  } state_e;

  state_e               state_q;
  logic [ECW-1:0]       elem_q, elem_next;
  logic [BATCH_W-1:0]   batch_q;
  logic [CH_W-1:0]      chan_q;
  logic [DW-1:0]        i_q, j_q, t_q, dim_last;
  logic [AW-1:0]        row_q, bptr_q;
  logic [STEP_W-1:0]    step_q;
  logic                 job_end_q, batch_wrap, chan_wrap, i_last, j_last, t_last;

  assign elem_next  = elem_q + ECW'(1);
  assign batch_wrap = ({1'b0, batch_q} + 17'd1) >= {1'b0, batches_i};
  assign chan_wrap  = ({1'b0, chan_q} + CHCNT_W'(1)) >= channels_i;
  assign dim_last   = dim_i - DW'(1);
  assign i_last     = (i_q == dim_last);
  assign j_last     = (j_q == dim_last);
  assign t_last     = (t_q == dim_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      elem_q    <= '0;
      batch_q   <= '0;
      chan_q    <= '0;
      i_q       <= '0;
      j_q       <= '0;
      t_q       <= '0;
      row_q     <= '0;
      bptr_q    <= '0;
      step_q    <= '0;
      job_end_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept_i) begin
            if (elem_next >= elems_i) begin
              elem_q    <= '0;
              job_end_q <= batch_wrap && chan_wrap;
              i_q       <= '0;
              j_q       <= '0;
              t_q       <= '0;
              row_q     <= '0;
              bptr_q    <= '0;
              state_q   <= S_READ;
            end else begin
              elem_q <= elem_next;
            end
          end
        end
        S_READ: state_q <= S_LOAD;
        S_LOAD: begin
          step_q  <= '0;
          state_q <= S_AMOD;
        end
        S_AMOD: begin
          step_q <= step_q + STEP_W'(1);
          if (&step_q) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          step_q <= step_q + STEP_W'(1);
          if (&step_q) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (t_last) begin
            state_q <= S_EMIT;
          end else begin
            t_q     <= t_q + DW'(1);
            bptr_q  <= bptr_q + AW'(dim_i);
            state_q <= S_READ;
          end
        end
        S_EMIT: begin
          t_q     <= '0;
          state_q <= S_READ;
          if (j_last) begin
            j_q    <= '0;
            bptr_q <= '0;
            if (i_last) begin
              // matrix done: advance batch, then channel
              state_q <= S_IDLE;
              if (batch_wrap) begin
                batch_q <= '0;
                chan_q  <= chan_wrap ? '0 : chan_q + CH_W'(1);
              end else begin
                batch_q <= batch_q + BATCH_W'(1);
              end
            end else begin
              i_q   <= i_q + DW'(1);
              row_q <= row_q + AW'(dim_i);
            end
          end else begin
            j_q    <= j_q + DW'(1);
            bptr_q <= AW'(j_q + DW'(1));
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o    = (state_q != S_IDLE);
  assign waddr_o   = AW'(elem_q);
  assign a_raddr_o = row_q + AW'(t_q);
  assign b_raddr_o = bptr_q;
  assign channel_o = chan_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_LOAD);
    cmd_o.amod_step = (state_q == S_AMOD);
    cmd_o.mul_step  = (state_q == S_MUL);
    cmd_o.acc_add   = (state_q == S_ACC);
    cmd_o.acc_first = (t_q == '0);
    stat_o                = '0;
    stat_o.emit           = (state_q == S_EMIT);
    stat_o.last_of_matrix = i_last && j_last;
    stat_o.last_of_job    = i_last && j_last && job_end_q;
  end

endmodule

@@ hw/rtl/rns_batched_matrix_mul_mod_top.sv @@
// ----------------------------------------------------------------------------
// rns_batched_matrix_mul_mod_top
// Batched m x m matrix product modulo per-channel RNS moduli.
// ----------------------------------------------------------------------------
// Feed element pairs (A[k], B[k]) in row-major order, channel-major then
// batch, one per start pulse while busy is low. An item that does not
// finish a matrix pair is written to the stores and busy stays low. The
// item that finishes it raises busy; the block then emits the m*m
// elements of C = A*B mod p row by row, each as a one-cycle strobe on
// out_valid_o that the receiver must take on that cycle. Every product
// term runs through one bit-serial modular MAC in these steps: store
// read, operand load, 32 steps of a mod p, 32 steps of the multiply and
// one accumulate; each element then ends with an emit. Modulus zero
// acts as 2^32. Configuration writes are always taken (cfg_ready_o is tied
// high) and belong in idle time only.
// ----------------------------------------------------------------------------
module rns_batched_matrix_mul_mod_top import rbmm_pkg::*; #(
  parameter int MAX_DIM      = 8,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_i,
  output logic                 out_valid_o,
  output out_item_t            out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int ECW   = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0]  modulus_q [4];
  logic [CHCNT_W-1:0] chcnt_q;
  logic [SIZE_W-1:0]  size_q;
  logic [BATCH_W-1:0] batch_cnt_q;

  logic               accept, cfg_we;
  logic [DW-1:0]      dim;
  logic [ECW-1:0]     elems;
  logic [BATCH_W-1:0] batches;
  logic [CHCNT_W-1:0] channels;
  logic [MOD_W-1:0]   modulus;
  logic [AW-1:0]      waddr, a_raddr, b_raddr;
  logic [CH_W-1:0]    channel;
  logic [WORD_W-1:0]  a_data, b_data, acc;
  dp_cmd_t            cmd;
  ctrl_stat_t         stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = start && !busy;

  // Hold the register file; writes land at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        modulus_q[k] <= WORD_W'(2);
      end
      chcnt_q     <= CHCNT_W'(1);
      size_q      <= SIZE_W'(1);
      batch_cnt_q <= BATCH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_MODULUS_0:     modulus_q[0] <= cfg_data_i;
        REG_MODULUS_1:     modulus_q[1] <= cfg_data_i;
        REG_MODULUS_2:     modulus_q[2] <= cfg_data_i;
        REG_MODULUS_3:     modulus_q[3] <= cfg_data_i;
        REG_CHANNEL_COUNT: chcnt_q      <= cfg_data_i[CHCNT_W-1:0];
        REG_MATRIX_SIZE:   size_q       <= cfg_data_i[SIZE_W-1:0];
        REG_BATCH_COUNT:   batch_cnt_q  <= cfg_data_i[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the register values into their working range; modulus zero maps to 2^32
  always_comb begin
    if (size_q == '0) begin
      dim = DW'(1);
    end else if (int'(size_q) > MAX_DIM) begin
      dim = DW'(MAX_DIM);
    end else begin
      dim = DW'(size_q);
    end
    if (chcnt_q == '0) begin
      channels = CHCNT_W'(1);
    end else if (int'(chcnt_q) > MAX_CHANNELS) begin
      channels = CHCNT_W'(MAX_CHANNELS);
    end else begin
      channels = chcnt_q;
    end
    batches = (batch_cnt_q == '0) ? BATCH_W'(1) : batch_cnt_q;
    elems   = ECW'(ECW'(dim) * ECW'(dim));
    modulus = (modulus_q[channel] == '0) ? {1'b1, {WORD_W{1'b0}}}
                                         : {1'b0, modulus_q[channel]};
  end

  rbmm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH), .AW(AW)) u_left_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (in_i.a_element),
    .raddr_i (a_raddr),
    .rdata_o (a_data)
  );

  rbmm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH), .AW(AW)) u_right_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (in_i.b_element),
    .raddr_i (b_raddr),
    .rdata_o (b_data)
  );

  rbmm_ctrl #(.MAX_DIM(MAX_DIM), .DW(DW), .ECW(ECW), .AW(AW)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .dim_i      (dim),
    .elems_i    (elems),
    .batches_i  (batches),
    .channels_i (channels),
    .busy_o     (busy),
    .waddr_o    (waddr),
    .a_raddr_o  (a_raddr),
    .b_raddr_o  (b_raddr),
    .channel_o  (channel),
    .cmd_o      (cmd),
    .stat_o     (stat)
  );

  rbmm_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .a_data_i  (a_data),
    .b_data_i  (b_data),
    .modulus_i (modulus),
    .acc_o     (acc)
  );

  // Drive the result transfer straight from the accumulator register
  assign out_valid_o           = stat.emit;
  assign out_o.product_element = acc;
  assign out_o.last_of_matrix  = stat.last_of_matrix;
  assign out_o.last_of_job     = stat.last_of_job;

endmodule

@@ hw/rtl/rbmm_checker.sv @@
// ----------------------------------------------------------------------------
// rbmm_checker
// Port-level checks of the matrix multiplier, bound to its top level.
// ----------------------------------------------------------------------------
module rbmm_checker import rbmm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      busy,
  input logic      out_valid_o,
  input out_item_t out_o
);

  a_out_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result outside a busy window");

  a_job_implies_matrix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.last_of_job) |-> out_o.last_of_matrix)
    else $error("job end without matrix end");

  a_busy_ends_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(out_valid_o && out_o.last_of_matrix))
    else $error("busy dropped before the last element");

  a_results_spaced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("back-to-back results");

endmodule

bind rns_batched_matrix_mul_mod_top rbmm_checker u_rbmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .out_valid_o (out_valid_o),
  .out_o       (out_o)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the batched RNS modular matrix multiplier: drives
// element pairs and register writes, predicts every product element and
// compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbmm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // cycles without any transfer
  localparam int SETTLE_CYCLES  = 20;

  // Predicts C = A*B mod p for each completed matrix pair and holds the
  // product elements still owed by the block.
  class product_board;
    logic [WORD_W-1:0] modulus [4];
    logic [CHCNT_W-1:0] chan_cnt;
    logic [SIZE_W-1:0]  mat_size;
    logic [BATCH_W-1:0] batch_cnt;
    logic [WORD_W-1:0] a_mem [64];
    logic [WORD_W-1:0] b_mem [64];
    int elem_idx, batch_idx, chan_idx;
    out_item_t owed [$];
    int errors, compared, matrices, jobs;

    function void reset_state();
      for (int i = 0; i < 4; i++) modulus[i] = 2;
      chan_cnt = 1; mat_size = 1; batch_cnt = 1;
      elem_idx = 0; batch_idx = 0; chan_idx = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
      case (idx)
        REG_MODULUS_0, REG_MODULUS_1, REG_MODULUS_2, REG_MODULUS_3: begin
          modulus[idx[1:0]] = val;
        end
        REG_CHANNEL_COUNT: chan_cnt = val[CHCNT_W-1:0];
        REG_MATRIX_SIZE:   mat_size = val[SIZE_W-1:0];
        REG_BATCH_COUNT:   batch_cnt = val[BATCH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pair(in_item_t it);
      int m, kc, bc;
      logic [63:0] p, acc, prod;
      logic job_end;
      out_item_t r;
      m  = (mat_size == 0) ? 1 : (mat_size > 8 ? 8 : mat_size);
      kc = (chan_cnt == 0) ? 1 : (chan_cnt > 4 ? 4 : chan_cnt);
      bc = (batch_cnt == 0) ? 1 : batch_cnt;
      a_mem[elem_idx & 63] = it.a_element;
      b_mem[elem_idx & 63] = it.b_element;
      elem_idx = (elem_idx + 1) & 127;
      if (elem_idx < m * m) return;
      p = modulus[chan_idx & 3];
      if (p == 0) p = 64'h1_0000_0000;
      job_end = (batch_idx + 1 >= bc) && (chan_idx + 1 >= kc);
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < m; j++) begin
          acc = 0;
          for (int t = 0; t < m; t++) begin
            prod = (64'(a_mem[(i*m+t) & 63]) * 64'(b_mem[(t*m+j) & 63])) % p;
            acc = (prod + acc) % p;
          end
          r.product_element = acc[WORD_W-1:0];
          r.last_of_matrix  = (i == m-1) && (j == m-1);
          r.last_of_job     = job_end && r.last_of_matrix;
          owed.push_back(r);
        end
      end
      matrices++;
      if (job_end) jobs++;
      elem_idx = 0;
      if (batch_idx + 1 >= bc) begin
        batch_idx = 0;
        chan_idx = (chan_idx + 1 >= kc) ? 0 : ((chan_idx + 1) & 3);
      end else begin
        batch_idx = (batch_idx + 1) & 16'hFFFF;
      end
    endfunction

    function void check_product(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected product %h", got);
        return;
      end
      want = owed.pop_front();
      compared++;
      if (got.product_element !== want.product_element ||
          got.last_of_matrix !== want.last_of_matrix ||
          got.last_of_job !== want.last_of_job) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: product exp %h/%b/%b got %h/%b/%b",
                   want.product_element, want.last_of_matrix, want.last_of_job,
                   got.product_element, got.last_of_matrix, got.last_of_job);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_i = '0;
  logic out_valid_o;
  out_item_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0] cfg_data_i = '0;

  product_board board = new();
  int quiet_cycles = 0;
  int sent = 0;
  int calm_lo, calm_hi;  // stretch of items sent with no sender gaps

  always #5 clk_i = ~clk_i;

  rns_batched_matrix_mul_mod_top dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .out_valid_o, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Monitor: note accepted pairs, check strobed products, watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_pair(in_i);
      if (out_valid_o) board.check_product(out_o);
      if ((start && !busy) || out_valid_o || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Hold valid across back-to-back writes; the caller drops it afterwards.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
  endtask

  task automatic send_pair(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    // Insert a random gap outside the calm stretch.
    if (!(sent >= calm_lo && sent < calm_hi)) begin
      while ($urandom_range(99) < 19) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    in_i.a_element <= a;
    in_i.b_element <= b;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  // Hold off new pairs until the block has delivered everything it owes.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.owed.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(15);
      3: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_modulus();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd2;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(3, 1000);
      default: return $urandom | 32'd2;
    endcase
  endfunction

  task automatic set_job(logic [WORD_W-1:0] m0, logic [WORD_W-1:0] m1,
                         logic [WORD_W-1:0] m2, logic [WORD_W-1:0] m3,
                         int chans, int size, int batches);
    write_cfg(REG_MODULUS_0, m0);
    write_cfg(REG_MODULUS_1, m1);
    write_cfg(REG_MODULUS_2, m2);
    write_cfg(REG_MODULUS_3, m3);
    write_cfg(REG_CHANNEL_COUNT, chans);
    write_cfg(REG_MATRIX_SIZE, size);
    write_cfg(REG_BATCH_COUNT, batches);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_matrices(int size, int count, bit pause_mid);
    int m;
    m = (size == 0) ? 1 : (size > 8 ? 8 : size);
    for (int k = 0; k < count; k++) begin
      for (int e = 0; e < m * m; e++) begin
        send_pair(rand_word(), rand_word());
      end
      if (pause_mid && k == count / 2) drain();
    end
  endtask

  initial begin
    int size, mats;
    calm_lo = 150;
    calm_hi = 230;
    board.reset_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 1x1 extremes across four channels with modulus 2^32, 1, max, 2.
    set_job(32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 4, 1, 2);
    send_pair('1, '1); send_pair('1, 32'd0); send_pair(32'd0, '1); send_pair('1, '1);
    send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF); send_pair(32'd7, 32'd9);
    send_pair('1, '1); send_pair(32'd3, 32'd5);
    drain();
    // Out-of-range counts: size 0, channels 0, batch 0 all act as one.
    set_job(32'd12345, 32'd0, 32'd0, 32'd0, 0, 0, 0);
    send_pair('1, '1); send_pair(32'd12345, 32'd2); send_pair(32'd0, 32'd0);
    drain();
    // Channels above the limit, 2x2 with all-ones operands.
    set_job(32'hFFFF_FFFF, 32'd0, 32'd1, 32'd65521, 7, 2, 1);
    for (int k = 0; k < 8; k++) send_pair('1, '1);
    drain();
    // Size above the limit clamps to the largest matrix, big batch count.
    set_job(rand_modulus(), rand_modulus(), rand_modulus(), rand_modulus(),
            5, 15, 16'hFFFF);
    send_matrices(15, 1, 1'b0);
    drain();

    // Random phases, mostly small sizes.
    while (sent < 430) begin
      size = $urandom_range(1, 4);
      if ($urandom_range(9) == 0) size = 0;
      mats = $urandom_range(1, 6);
      set_job(rand_modulus(), rand_modulus(), rand_modulus(), rand_modulus(),
              ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4),
              size,
              ($urandom_range(9) == 0) ? 16'hFFFF : $urandom_range(0, 3));
      send_matrices(size, mats, $urandom_range(3) == 0);
      drain();
    end

    $display("Covered %0d element pairs, %0d matrices, %0d finished jobs,",
             sent, board.matrices, board.jobs);
    $display("%0d product elements compared, %0d mismatches",
             board.compared, board.errors);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/rbmm_pkg.sv
hw/rtl/rbmm_ram.sv
hw/rtl/rbmm_dp.sv
hw/rtl/rbmm_ctrl.sv
hw/rtl/rns_batched_matrix_mul_mod_top.sv
hw/rtl/rbmm_checker.sv
test/tb.sv
